// ===== design/ehtt_pkg.sv =====
// Package for the epoch hash tag tracker: table geometry, command and status codes,
// and the hash constants. Depends on nothing.
package ehtt_pkg;

  localparam int TableSize = 1024;
  localparam int IdxW = $clog2(TableSize);
  localparam int MaxProbes = 8;
  localparam int ProbeW = 7;
  localparam int EpochW = 16;
  localparam logic [31:0] MixC1 = 32'h85ebca6b;
  localparam logic [31:0] MixC2 = 32'hc2b2ae35;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    CMD_MARK    = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADVANCED = 3'd0,
    ST_HIT      = 3'd1,
    ST_MISS     = 3'd2,
    ST_INSERTED = 3'd3,
    ST_MERGED   = 3'd4,
    ST_DROPPED  = 3'd5,
    ST_NULL     = 3'd6
  } status_e;

  // Kinds of work the front end hands to the back end.
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_MARK    = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_ADVANCE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_READ  = 3'd1,
    BK_CHECK = 3'd2,
    BK_MERGE = 3'd3,
    BK_OUT   = 3'd4
  } bk_state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] layer_index;
    logic [3:0]  tag;
    logic [7:0]  stage;
  } item_t;

  typedef struct packed {
    op_e             op;
    status_e         status;
    logic [IdxW-1:0] home;
    item_t           item;
  } job_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  found_tag;
    logic [7:0]  found_stage;
    logic [31:0] found_layer;
    logic [2:0]  conflict_mask;
    logic [6:0]  probes_used;
    logic [15:0] epoch_now;
    logic [31:0] conflicting_entries;
    logic [31:0] tag_conflicts;
    logic [31:0] stage_conflicts;
    logic [31:0] layer_conflicts;
  } result_t;

endpackage

// ===== design/ehtt_if.sv =====
// Valid/ready channel interfaces for items, results and the configuration write.
// Depends on nothing.
interface ehtt_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] key;
  logic [31:0] layer_index;
  logic [3:0]  tag;
  logic signed [7:0] stage;
  modport source (output valid, command, key, layer_index, tag, stage, input ready);
  modport sink (input valid, command, key, layer_index, tag, stage, output ready);
endinterface

interface ehtt_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  found_tag;
  logic signed [7:0] found_stage;
  logic [31:0] found_layer;
  logic [2:0]  conflict_mask;
  logic [6:0]  probes_used;
  logic [15:0] epoch_now;
  logic [31:0] conflicting_entries;
  logic [31:0] tag_conflicts;
  logic [31:0] stage_conflicts;
  logic [31:0] layer_conflicts;
  modport source (output valid, status, found_tag, found_stage, found_layer, conflict_mask,
                  probes_used, epoch_now, conflicting_entries, tag_conflicts,
                  stage_conflicts, layer_conflicts, input ready);
  modport sink (input valid, status, found_tag, found_stage, found_layer, conflict_mask,
                probes_used, epoch_now, conflicting_entries, tag_conflicts,
                stage_conflicts, layer_conflicts, output ready);
endinterface

interface ehtt_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/ehtt_front.sv =====
// Front end: accepts items, classifies them and computes the home slot with a
// two-stage murmur finalizer. Depends on ehtt_pkg.
module ehtt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      command_i,
  input  ehtt_pkg::item_t item_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output ehtt_pkg::job_t  job_o
);

  // Stage 1 holds the first product, stage 2 the second, then the job is built.
  logic            s1_valid_q, s1_valid_d;
  logic            s2_valid_q, s2_valid_d;
  logic            out_valid_q, out_valid_d;
  ehtt_pkg::op_e     s1_op_q, s2_op_q, out_op_q;
  ehtt_pkg::status_e s1_st_q, s2_st_q, out_st_q;
  ehtt_pkg::item_t   s1_item_q, s2_item_q, out_item_q;
  logic [31:0]     s1_mul_q, s2_mul_q;
  logic [ehtt_pkg::IdxW-1:0] out_home_q;

  logic [31:0] x0, x1, x2;
  ehtt_pkg::op_e     op_c;
  ehtt_pkg::status_e st_c;
  logic adv_out, adv_s2, adv_s1;

  always_comb begin
    op_c = ehtt_pkg::OP_NONE;
    st_c = ehtt_pkg::ST_MISS;
    case (ehtt_pkg::cmd_e'(command_i))
      ehtt_pkg::CMD_ADVANCE: begin
        op_c = ehtt_pkg::OP_ADVANCE;
        st_c = ehtt_pkg::ST_ADVANCED;
      end
      ehtt_pkg::CMD_MARK: begin
        if (item_i.key == 32'd0) st_c = ehtt_pkg::ST_NULL;
        else op_c = ehtt_pkg::OP_MARK;
      end
      ehtt_pkg::CMD_LOOKUP: begin
        if (item_i.key == 32'd0) st_c = ehtt_pkg::ST_NULL;
        else op_c = ehtt_pkg::OP_LOOKUP;
      end
      default: begin
        op_c = ehtt_pkg::OP_NONE;
      end
    endcase
  end

  assign adv_out = !out_valid_q || job_ready_i;
  assign adv_s2  = !s2_valid_q || adv_out;
  assign adv_s1  = !s1_valid_q || adv_s2;
  assign in_ready_o = adv_s1;

  assign x0 = item_i.key ^ (item_i.key >> 16);
  assign x1 = s1_mul_q ^ (s1_mul_q >> 13);
  assign x2 = s2_mul_q ^ (s2_mul_q >> 16);

  always_comb begin
    s1_valid_d  = adv_s1 ? in_valid_i : s1_valid_q;
    s2_valid_d  = adv_s2 ? s1_valid_q : s2_valid_q;
    out_valid_d = adv_out ? s2_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1) begin
      s1_op_q   <= op_c;
      s1_st_q   <= st_c;
      s1_item_q <= item_i;
      s1_mul_q  <= x0 * ehtt_pkg::MixC1;
    end
    if (adv_s2) begin
      s2_op_q   <= s1_op_q;
      s2_st_q   <= s1_st_q;
      s2_item_q <= s1_item_q;
      s2_mul_q  <= x1 * ehtt_pkg::MixC2;
    end
    if (adv_out) begin
      out_op_q   <= s2_op_q;
      out_st_q   <= s2_st_q;
      out_item_q <= s2_item_q;
      out_home_q <= x2[ehtt_pkg::IdxW-1:0];
    end
  end

  assign job_valid_o = out_valid_q;
  always_comb begin
    job_o.op     = out_op_q;
    job_o.status = out_st_q;
    job_o.home   = out_home_q;
    job_o.item   = out_item_q;
  end

endmodule

// ===== design/ehtt_queue.sv =====
// Short FIFO of jobs between the front and back ends. Depends on ehtt_pkg.
module ehtt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  ehtt_pkg::job_t wr_job_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output ehtt_pkg::job_t rd_job_o
);

  localparam int PtrW = $clog2(ehtt_pkg::QDepth);
  ehtt_pkg::job_t mem_q [ehtt_pkg::QDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic do_wr, do_rd;

  assign wr_ready_o = cnt_q != ehtt_pkg::QDepth[PtrW:0];
  assign rd_valid_o = cnt_q != '0;
  assign do_wr = wr_valid_i && wr_ready_o;
  assign do_rd = rd_valid_o && rd_ready_i;
  assign rd_job_o = mem_q[rp_q];

  always_comb begin
    wp_d  = do_wr ? wp_q + 1'b1 : wp_q;
    rp_d  = do_rd ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + {{PtrW{1'b0}}, do_wr} - {{PtrW{1'b0}}, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_job_i;
  end

endmodule

// ===== design/ehtt_back.sv =====
// Back end: probes the slot memory one slot at a time (read, then check), merges or fills,
// and keeps the epoch and the conflict counters. Depends on ehtt_pkg.
module ehtt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  ehtt_pkg::job_t   job_i,
  input  logic [31:0]      unknown_layer_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output ehtt_pkg::result_t res_o
);

  localparam int IW = ehtt_pkg::IdxW;
  localparam int TsLocal = ehtt_pkg::TableSize;
  localparam int BitW = (TsLocal + 1 > 2) ? $clog2(TsLocal + 1) : 1;

  // Slot data lives in one memory. After reset a sweep over all TableSize slots
  // clears it, so that every key reads as empty.
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] epoch;
    logic [3:0]  tag;
    logic [7:0]  stage;
    logic [31:0] layer;
    logic [2:0]  conf;
  } slot_t;

  slot_t slot_mem [TsLocal];
  slot_t rd_q;

  ehtt_pkg::bk_state_e state_q, state_d;
  ehtt_pkg::job_t job_q;
  logic [IW-1:0]  addr_q, addr_d;
  logic [6:0]     probes_q, probes_d;
  logic [15:0]    epoch_q, epoch_d;
  logic [31:0]    cnt_q [4];
  logic [31:0]    cnt_d [4];
  logic [BitW-1:0] clr_q;
  logic           clearing;
  ehtt_pkg::result_t res_q, res_d;
  ehtt_pkg::result_t out_q;
  logic           res_valid_q, res_valid_d;

  logic wr_en;
  logic [IW-1:0] wr_addr;
  slot_t wr_data;

  slot_t fresh, merged;
  logic [2:0] mask, added;
  logic key_eq, ep_eq, empty;
  logic [15:0] ep_inc;

  assign clearing = clr_q != TsLocal[BitW-1:0];
  assign job_ready_o = !clearing && state_q == ehtt_pkg::BK_IDLE;
  assign key_eq = rd_q.key == job_q.item.key;
  assign ep_eq  = rd_q.epoch == epoch_q;
  assign empty  = rd_q.key == 32'd0;
  assign ep_inc = epoch_q + 16'd1;

  always_comb begin
    fresh.key   = job_q.item.key;
    fresh.epoch = epoch_q;
    fresh.tag   = job_q.item.tag;
    fresh.stage = job_q.item.stage;
    fresh.layer = job_q.item.layer_index;
    fresh.conf  = 3'd0;
    merged = rd_q;
    mask = 3'd0;
    if (job_q.item.tag != 4'd0) begin
      if (rd_q.tag == 4'd0) merged.tag = job_q.item.tag;
      else if (rd_q.tag != job_q.item.tag) mask[0] = 1'b1;
    end
    if (!job_q.item.stage[7]) begin
      if (rd_q.stage[7]) merged.stage = job_q.item.stage;
      else if (rd_q.stage != job_q.item.stage) mask[1] = 1'b1;
    end
    if (job_q.item.layer_index != unknown_layer_i) begin
      if (rd_q.layer == unknown_layer_i) merged.layer = job_q.item.layer_index;
      else if (rd_q.layer != job_q.item.layer_index) mask[2] = 1'b1;
    end
    added = mask & ~rd_q.conf;
    merged.conf = rd_q.conf | mask;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ehtt_pkg::BK_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          if (job_i.op == ehtt_pkg::OP_MARK || job_i.op == ehtt_pkg::OP_LOOKUP)
            state_d = ehtt_pkg::BK_READ;
          else state_d = ehtt_pkg::BK_OUT;
        end
      end
      ehtt_pkg::BK_READ: state_d = ehtt_pkg::BK_CHECK;
      ehtt_pkg::BK_CHECK: begin
        if (job_q.op == ehtt_pkg::OP_MARK) begin
          if (key_eq && ep_eq) state_d = ehtt_pkg::BK_MERGE;
          else if (key_eq || empty || !ep_eq) state_d = ehtt_pkg::BK_OUT;
          else if (probes_q == 7'(ehtt_pkg::MaxProbes)) state_d = ehtt_pkg::BK_OUT;
          else state_d = ehtt_pkg::BK_READ;
        end else begin
          if ((key_eq && ep_eq) || empty) state_d = ehtt_pkg::BK_OUT;
          else if (probes_q == 7'(ehtt_pkg::MaxProbes)) state_d = ehtt_pkg::BK_OUT;
          else state_d = ehtt_pkg::BK_READ;
        end
      end
      ehtt_pkg::BK_MERGE: state_d = ehtt_pkg::BK_OUT;
      ehtt_pkg::BK_OUT: begin
        if (!res_valid_q || res_ready_i) state_d = ehtt_pkg::BK_IDLE;
      end
      default: state_d = ehtt_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    addr_d   = addr_q;
    probes_d = probes_q;
    epoch_d  = epoch_q;
    for (int i = 0; i < 4; i++) cnt_d[i] = cnt_q[i];
    res_d = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = fresh;
    case (state_q)
      ehtt_pkg::BK_IDLE: begin
        addr_d   = job_i.home;
        probes_d = 7'd0;
        res_d.status        = job_i.status;
        res_d.found_tag     = 4'd0;
        res_d.found_stage   = 8'hFF;
        res_d.found_layer   = 32'd0;
        res_d.conflict_mask = 3'd0;
        if (job_valid_i && job_ready_o && job_i.op == ehtt_pkg::OP_ADVANCE)
          epoch_d = (ep_inc == 16'd0) ? 16'd1 : ep_inc;
        if (job_i.op == ehtt_pkg::OP_MARK) res_d.status = ehtt_pkg::ST_DROPPED;
        if (job_i.op == ehtt_pkg::OP_LOOKUP) res_d.status = ehtt_pkg::ST_MISS;
      end
      ehtt_pkg::BK_READ: begin
        probes_d = probes_q + 7'd1;
      end
      ehtt_pkg::BK_CHECK: begin
        addr_d = addr_q + 1'b1;
        if (job_q.op == ehtt_pkg::OP_MARK) begin
          if (key_eq && ep_eq) begin
            addr_d = addr_q;
            res_d.status = ehtt_pkg::ST_MERGED;
          end else if (key_eq || empty || !ep_eq) begin
            wr_en = 1'b1;
            res_d.status = ehtt_pkg::ST_INSERTED;
          end
        end else if (key_eq && ep_eq) begin
          res_d.status        = ehtt_pkg::ST_HIT;
          res_d.found_tag     = rd_q.tag;
          res_d.found_stage   = rd_q.stage;
          res_d.found_layer   = rd_q.layer;
          res_d.conflict_mask = rd_q.conf;
        end
      end
      ehtt_pkg::BK_MERGE: begin
        wr_en   = 1'b1;
        wr_data = merged;
        if (added != 3'd0) begin
          if (rd_q.conf == 3'd0 && cnt_q[0] != '1) cnt_d[0] = cnt_q[0] + 32'd1;
          for (int i = 0; i < 3; i++) begin
            if (added[i] && cnt_q[i+1] != '1) cnt_d[i+1] = cnt_q[i+1] + 32'd1;
          end
        end
      end
      ehtt_pkg::BK_OUT: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          res_d.probes_used         = probes_q;
          res_d.epoch_now           = epoch_q;
          res_d.conflicting_entries = cnt_q[0];
          res_d.tag_conflicts       = cnt_q[1];
          res_d.stage_conflicts     = cnt_q[2];
          res_d.layer_conflicts     = cnt_q[3];
        end
      end
      default: ;
    endcase
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_q[IW-1:0];
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ehtt_pkg::BK_IDLE;
      epoch_q     <= 16'd1;
      for (int i = 0; i < 4; i++) cnt_q[i] <= 32'd0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      probes_q    <= 7'd0;
      addr_q      <= '0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_d[i];
      if (clearing) clr_q <= clr_q + 1'b1;
      res_valid_q <= res_valid_d;
      probes_q    <= probes_d;
      addr_q      <= addr_d;
    end
  end

  // The finished result moves into its own register, so the next job can be
  // worked on while this beat waits for the receiver.
  always_ff @(posedge clk_i) begin
    if (state_q == ehtt_pkg::BK_IDLE && job_valid_i && job_ready_o) job_q <= job_i;
    res_q <= res_d;
    if (state_q == ehtt_pkg::BK_OUT && (!res_valid_q || res_ready_i)) out_q <= res_d;
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    rd_q <= slot_mem[addr_q];
  end

  assign res_valid_o = res_valid_q;
  assign res_o = out_q;

endmodule

// ===== design/epoch_hash_tag_tracker_core.sv =====
// Epoch hash tag tracker: an epoch-tagged open-addressing table with linear probing.
//
// Channels: item_in carries command, key, layer_index, tag and stage; result_out
// carries one result beat per item; cfg_in writes unknown_layer_value (reset all ones).
// The front end hashes the key in a pipeline of registers (s1, s2, out) and queues
// the job; the back end reads one slot at a time (memory read, then compare), and
// a mark that finds its key in the current epoch takes a further merge step;
// advance, null key and unused command go straight to the result.
// After reset the key memory is cleared by a sweep, during which beats are held
// in the front end and queue; configuration writes are always taken.
// When the receiver stalls, the finished result waits in the output register and
// the front end keeps accepting until its pipeline and the queue are full.
module epoch_hash_tag_tracker_core (
  input  logic clk_i,
  input  logic rst_ni,
  ehtt_item_if.sink     item_in,
  ehtt_result_if.source result_out,
  ehtt_cfg_if.sink      cfg_in
);

  logic [31:0] unknown_layer_q;
  ehtt_pkg::item_t item;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  ehtt_pkg::job_t fj, bj;
  ehtt_pkg::result_t res;

  assign cfg_in.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) unknown_layer_q <= 32'hFFFF_FFFF;
    else if (cfg_in.valid) unknown_layer_q <= cfg_in.data;
  end

  always_comb begin
    item.key         = item_in.key;
    item.layer_index = item_in.layer_index;
    item.tag         = item_in.tag;
    item.stage       = item_in.stage;
  end

  ehtt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (item_in.valid), .in_ready_o (item_in.ready),
    .command_i (item_in.command), .item_i (item),
    .job_valid_o (fj_valid), .job_ready_i (fj_ready), .job_o (fj)
  );

  ehtt_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (fj_valid), .wr_ready_o (fj_ready), .wr_job_i (fj),
    .rd_valid_o (bj_valid), .rd_ready_i (bj_ready), .rd_job_o (bj)
  );

  ehtt_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (bj_valid), .job_ready_o (bj_ready), .job_i (bj),
    .unknown_layer_i (unknown_layer_q),
    .res_valid_o (result_out.valid), .res_ready_i (result_out.ready), .res_o (res)
  );

  assign result_out.status              = res.status;
  assign result_out.found_tag           = res.found_tag;
  assign result_out.found_stage         = res.found_stage;
  assign result_out.found_layer         = res.found_layer;
  assign result_out.conflict_mask       = res.conflict_mask;
  assign result_out.probes_used         = res.probes_used;
  assign result_out.epoch_now           = res.epoch_now;
  assign result_out.conflicting_entries = res.conflicting_entries;
  assign result_out.tag_conflicts       = res.tag_conflicts;
  assign result_out.stage_conflicts     = res.stage_conflicts;
  assign result_out.layer_conflicts     = res.layer_conflicts;

endmodule

// ===== dv/epoch_hash_tag_tracker_core_tb.sv =====
// Self-checking testbench for epoch_hash_tag_tracker_core: directed and random
// marks, lookups and epoch advances against an in-bench table predictor.
// Depends on ehtt_pkg, the channel interfaces in ehtt_if.sv and the core itself.
module epoch_hash_tag_tracker_core_tb;
  import ehtt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_e        command;
    logic [31:0] key;
    logic [31:0] layer_index;
    logic [3:0]  tag;
    logic [7:0]  stage;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  ehtt_item_if   item_if ();
  ehtt_result_if res_if ();
  ehtt_cfg_if    cfg_if ();

  epoch_hash_tag_tracker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (item_if),
    .result_out (res_if),
    .cfg_in     (cfg_if)
  );

  // Predicted table contents.
  logic [31:0] tbl_key   [TableSize];
  logic [15:0] tbl_epoch [TableSize];
  logic [3:0]  tbl_tag   [TableSize];
  logic [7:0]  tbl_stage [TableSize];
  logic [31:0] tbl_layer [TableSize];
  logic [2:0]  tbl_conf  [TableSize];
  logic [15:0] epoch_q;
  logic [31:0] conf_cnt [4];
  logic [31:0] layer_unknown;

  beat_t   pending_beats[$];
  result_t expected_results[$];
  beat_t   beat_on_wire;
  logic [31:0] cluster_keys[$];
  logic [31:0] key_pool[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int unexpected;

  function automatic logic [31:0] murmur_fin(logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * MixC1;
    v = v ^ (v >> 13);
    v = v * MixC2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic void sat_inc(int which);
    if (conf_cnt[which] != 32'hFFFF_FFFF) conf_cnt[which] = conf_cnt[which] + 1;
  endfunction

  function automatic void fill_entry(int s, beat_t b);
    tbl_key[s]   = b.key;
    tbl_epoch[s] = epoch_q;
    tbl_tag[s]   = b.tag;
    tbl_stage[s] = b.stage;
    tbl_layer[s] = b.layer_index;
    tbl_conf[s]  = 3'b000;
  endfunction

  function automatic void merge_entry(int s, beat_t b);
    logic [2:0] mask;
    logic [2:0] added;
    mask = 3'b000;
    if (b.tag != 4'd0) begin
      if (tbl_tag[s] == 4'd0) tbl_tag[s] = b.tag;
      else if (tbl_tag[s] != b.tag) mask[0] = 1'b1;
    end
    if (!b.stage[7]) begin
      if (tbl_stage[s][7]) tbl_stage[s] = b.stage;
      else if (tbl_stage[s] != b.stage) mask[1] = 1'b1;
    end
    if (b.layer_index != layer_unknown) begin
      if (tbl_layer[s] == layer_unknown) tbl_layer[s] = b.layer_index;
      else if (tbl_layer[s] != b.layer_index) mask[2] = 1'b1;
    end
    added = mask & ~tbl_conf[s];
    if (added != 3'b000) begin
      if (tbl_conf[s] == 3'b000) sat_inc(0);
      if (added[0]) sat_inc(1);
      if (added[1]) sat_inc(2);
      if (added[2]) sat_inc(3);
    end
    tbl_conf[s] = tbl_conf[s] | mask;
  endfunction

  // Applies one accepted beat to the predicted table and returns its result.
  function automatic result_t track_beat(beat_t b);
    result_t r;
    int home;
    int s;
    r = '0;
    r.status = ST_MISS;
    r.found_stage = 8'hFF;
    home = murmur_fin(b.key) % TableSize;
    if (b.command == CMD_ADVANCE) begin
      epoch_q = epoch_q + 16'd1;
      if (epoch_q == 16'd0) epoch_q = 16'd1;
      r.status = ST_ADVANCED;
    end else if (b.command != CMD_UNUSED && b.key == 32'd0) begin
      r.status = ST_NULL;
    end else if (b.command == CMD_MARK) begin
      r.status = ST_DROPPED;
      for (int p = 0; p < MaxProbes; p++) begin
        s = (home + p) % TableSize;
        r.probes_used = r.probes_used + 7'd1;
        if (tbl_key[s] == b.key) begin
          if (tbl_epoch[s] != epoch_q) begin
            fill_entry(s, b);
            r.status = ST_INSERTED;
          end else begin
            merge_entry(s, b);
            r.status = ST_MERGED;
          end
          break;
        end
        if (tbl_key[s] == 32'd0 || tbl_epoch[s] != epoch_q) begin
          fill_entry(s, b);
          r.status = ST_INSERTED;
          break;
        end
      end
    end else if (b.command == CMD_LOOKUP) begin
      for (int p = 0; p < MaxProbes; p++) begin
        s = (home + p) % TableSize;
        r.probes_used = r.probes_used + 7'd1;
        if (tbl_key[s] == b.key && tbl_epoch[s] == epoch_q) begin
          r.status        = ST_HIT;
          r.found_tag     = tbl_tag[s];
          r.found_stage   = tbl_stage[s];
          r.found_layer   = tbl_layer[s];
          r.conflict_mask = tbl_conf[s];
          break;
        end
        if (tbl_key[s] == 32'd0) break;
      end
    end
    r.epoch_now           = epoch_q;
    r.conflicting_entries = conf_cnt[0];
    r.tag_conflicts       = conf_cnt[1];
    r.stage_conflicts     = conf_cnt[2];
    r.layer_conflicts     = conf_cnt[3];
    return r;
  endfunction

  task automatic queue_beat(cmd_e c, logic [31:0] k, logic [31:0] l, logic [3:0] t,
                            logic [7:0] st);
    beat_t b;
    b.command = c;
    b.key = k;
    b.layer_index = l;
    b.tag = t;
    b.stage = st;
    pending_beats.push_back(b);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 32'd0;
    if (r < 55) return cluster_keys[$urandom_range(cluster_keys.size() - 1)];
    if (r < 90) return key_pool[$urandom_range(key_pool.size() - 1)];
    return $urandom;
  endfunction

  task automatic queue_random_beat();
    cmd_e c;
    int r;
    logic [31:0] l;
    logic [3:0] t;
    logic [7:0] st;
    r = $urandom_range(99);
    if (r < 66) c = CMD_MARK;
    else if (r < 92) c = CMD_LOOKUP;
    else if (r < 97) c = CMD_ADVANCE;
    else c = CMD_UNUSED;
    r = $urandom_range(99);
    if (r < 25) l = layer_unknown;
    else if (r < 75) l = $urandom_range(3);
    else l = $urandom;
    r = $urandom_range(99);
    if (r < 30) t = 4'd0;
    else if (r < 80) t = 4'($urandom_range(3, 1));
    else t = 4'($urandom);
    r = $urandom_range(99);
    if (r < 30) st = 8'($urandom_range(255, 128));
    else if (r < 85) st = 8'($urandom_range(3));
    else st = 8'($urandom_range(127));
    queue_beat(c, pick_key(), l, t, st);
  endtask

  // Waits until every queued beat has been sent and every result has come back,
  // then lets the back end drain before anything else happens.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_beats.size() != 0 || expected_results.size() != 0 || item_if.valid);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_unknown_layer(logic [31:0] v);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    forever begin
      @(posedge clk_i);
      if (cfg_if.valid && cfg_if.ready) break;
    end
    cfg_if.valid <= 1'b0;
    layer_unknown = v;
  endtask

  task automatic run_random_phase(int idle, int stall, int count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) queue_random_beat();
    wait_drained();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Item driver: a beat is predicted when it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid       <= 1'b0;
      item_if.command     <= CMD_MARK;
      item_if.key         <= '0;
      item_if.layer_index <= '0;
      item_if.tag         <= '0;
      item_if.stage       <= '0;
    end else begin
      if (item_if.valid && item_if.ready) expected_results.push_back(track_beat(beat_on_wire));
      if (!item_if.valid || item_if.ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_wire = pending_beats.pop_front();
          item_if.valid       <= 1'b1;
          item_if.command     <= beat_on_wire.command;
          item_if.key         <= beat_on_wire.key;
          item_if.layer_index <= beat_on_wire.layer_index;
          item_if.tag         <= beat_on_wire.tag;
          item_if.stage       <= beat_on_wire.stage;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.status              = status_e'(res_if.status);
        got.found_tag           = res_if.found_tag;
        got.found_stage         = res_if.found_stage;
        got.found_layer         = res_if.found_layer;
        got.conflict_mask       = res_if.conflict_mask;
        got.probes_used         = res_if.probes_used;
        got.epoch_now           = res_if.epoch_now;
        got.conflicting_entries = res_if.conflicting_entries;
        got.tag_conflicts       = res_if.tag_conflicts;
        got.stage_conflicts     = res_if.stage_conflicts;
        got.layer_conflicts     = res_if.layer_conflicts;
        if (expected_results.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10) $display("result beat with none expected: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [31:0] k;
    logic [31:0] h;
    rst_ni         = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    unexpected     = 0;
    epoch_q        = 16'd1;
    layer_unknown  = 32'hFFFF_FFFF;
    for (int i = 0; i < 4; i++) conf_cnt[i] = '0;
    for (int i = 0; i < TableSize; i++) begin
      tbl_key[i] = '0;
      tbl_epoch[i] = '0;
      tbl_tag[i] = '0;
      tbl_stage[i] = '0;
      tbl_layer[i] = '0;
      tbl_conf[i] = '0;
    end
    // Keys whose home slots straddle the wrap point, so probing runs long,
    // wraps around the table and eventually drops.
    while (cluster_keys.size() < 16) begin
      k = $urandom;
      h = murmur_fin(k);
      if (k != 32'd0 && (h[9:0] >= 10'd1022 || h[9:0] <= 10'd1)) cluster_keys.push_back(k);
    end
    key_pool.push_back(32'hFFFF_FFFF);
    key_pool.push_back(32'h0000_0001);
    for (int i = 0; i < 30; i++) key_pool.push_back($urandom);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part.
    queue_beat(CMD_MARK, 32'd0, 32'd7, 4'd3, 8'd3);
    queue_beat(CMD_LOOKUP, 32'd0, 32'd0, 4'd0, 8'hFF);
    queue_beat(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 8'h7F);
    queue_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 4'd0, 8'd0);
    queue_beat(CMD_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 8'hFF);
    queue_beat(CMD_MARK, 32'hFFFF_FFFF, 32'd0, 4'hF, 8'd127);
    queue_beat(CMD_MARK, 32'hFFFF_FFFF, 32'd1, 4'd1, 8'd0);
    queue_beat(CMD_MARK, 32'hFFFF_FFFF, 32'd2, 4'd2, 8'h80);
    queue_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 4'd0, 8'd0);
    queue_beat(CMD_ADVANCE, 32'd0, 32'd0, 4'd0, 8'd0);
    queue_beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 4'd0, 8'd0);
    queue_beat(CMD_MARK, 32'hFFFF_FFFF, 32'd9, 4'd9, 8'd9);
    for (int i = 0; i < 11; i++) queue_beat(CMD_MARK, cluster_keys[i], i, 4'd1, 8'd1);
    queue_beat(CMD_LOOKUP, cluster_keys[0], 32'd0, 4'd0, 8'd0);
    queue_beat(CMD_LOOKUP, cluster_keys[15], 32'd0, 4'd0, 8'd0);
    wait_drained();

    run_random_phase(0, 0, 230);
    write_unknown_layer(32'd0);
    run_random_phase(77, 0, 230);
    write_unknown_layer(32'd5);
    run_random_phase(0, 77, 230);
    write_unknown_layer($urandom);
    run_random_phase(33, 33, 230);

    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ehtt_pkg.sv
design/ehtt_if.sv
design/ehtt_front.sv
design/ehtt_queue.sv
design/ehtt_back.sv
design/epoch_hash_tag_tracker_core.sv
dv/epoch_hash_tag_tracker_core_tb.sv
